[rtl/core/fpp_pkg.sv]
// shared types, codes and the crc byte update of the framed packet parser
`default_nettype none

package fpp_pkg;

  localparam int MaxPayloadDef = 64;

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_DATA  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_GAP_TIMEOUT = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic       take;
    logic       load_dst;
    logic       load_src;
    logic       load_type;
    logic       load_seq;
    logic       load_len;
    logic       crc_init;
    logic       crc_add;
    logic       pay_write;
    logic       load_crclo;
    logic       out_single;
    logic [1:0] single_status;
    logic       emit_start;
    logic       emit_step;
  } fpp_cmd_t;

  typedef struct packed {
    logic sync1_hit;
    logic sync2_hit;
    logic gap_over;
    logic len_over;
    logic byte_zero;
    logic fill_done;
    logic crc_ok;
    logic out_free;
    logic emit_last;
  } fpp_sts_t;

  // msb-first ccitt update, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/fpp_if.sv]
// channel interfaces of the framed packet parser
`default_nettype none

interface fpp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] time_ms;
  modport source (output valid, rx_byte, time_ms, input ready);
  modport sink (input valid, rx_byte, time_ms, output ready);
endinterface

interface fpp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  dst_addr;
  logic [7:0]  src_addr;
  logic [7:0]  frame_type;
  logic [7:0]  seq_num;
  logic [6:0]  payload_len;
  logic [5:0]  byte_pos;
  logic [7:0]  data_byte;
  logic [15:0] frame_crc;
  logic        last;
  modport source (output valid, status, dst_addr, src_addr, frame_type, seq_num,
                  payload_len, byte_pos, data_byte, frame_crc, last, input ready);
  modport sink (input valid, status, dst_addr, src_addr, frame_type, seq_num,
                payload_len, byte_pos, data_byte, frame_crc, last, output ready);
endinterface

interface fpp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/fpp_datapath.sv]
// datapath: config registers, header capture, crc, payload memory, result register
`default_nettype none

module fpp_datapath import fpp_pkg::*; #(
  parameter int MAX_PAYLOAD = MaxPayloadDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [31:0] time_ms,
  input  wire fpp_cmd_t    cmd,
  output fpp_sts_t         sts,
  fpp_cfg_if.sink          cfg,
  fpp_out_if.source        res
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  logic [15:0] gap_timeout;
  logic [31:0] prev_time;
  logic [31:0] gap;
  logic [7:0]  byte_q;
  logic        gap_over;
  logic [7:0]  hdr_dst;
  logic [7:0]  hdr_src;
  logic [7:0]  hdr_type;
  logic [7:0]  hdr_seq;
  logic [6:0]  hdr_len;
  logic [6:0]  fill_count;
  logic [7:0]  crc_lo;
  logic [15:0] running_crc;
  logic [15:0] frame_crc;
  logic [5:0]  emit_idx;
  logic [5:0]  next_idx;
  logic [6:0]  last_idx;
  logic [7:0]  mem [MAX_PAYLOAD];
  logic [7:0]  mem_q;
  logic        rd_en;
  logic [AW-1:0] rd_addr;

  logic        out_valid;
  logic [1:0]  out_status;
  logic [7:0]  out_dst;
  logic [7:0]  out_src;
  logic [7:0]  out_type;
  logic [7:0]  out_seq;
  logic [6:0]  out_len;
  logic [5:0]  out_pos;
  logic [7:0]  out_data;
  logic [15:0] out_crc;
  logic        out_last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= 8'hAA;
      sync_second <= 8'h55;
      gap_timeout <= 16'd100;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SYNC_FIRST:  sync_first  <= cfg.data[7:0];
        CFG_SYNC_SECOND: sync_second <= cfg.data[7:0];
        CFG_GAP_TIMEOUT: gap_timeout <= cfg.data;
        default: ;
      endcase
    end
  end

  assign gap = time_ms - prev_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time <= '0;
    end else if (cmd.take) begin
      prev_time <= time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      byte_q   <= rx_byte;
      gap_over <= gap > {16'h0000, gap_timeout};
    end
  end

  // header, crc and frame bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load_dst)   hdr_dst  <= byte_q;
    if (cmd.load_src)   hdr_src  <= byte_q;
    if (cmd.load_type)  hdr_type <= byte_q;
    if (cmd.load_seq)   hdr_seq  <= byte_q;
    if (cmd.load_crclo) crc_lo   <= byte_q;
    if (cmd.load_len) begin
      hdr_len    <= byte_q[6:0];
      fill_count <= '0;
    end else if (cmd.pay_write) begin
      fill_count <= fill_count + 7'd1;
    end
    if (cmd.crc_init) begin
      running_crc <= CRC_INIT;
    end else if (cmd.crc_add) begin
      running_crc <= crc16_byte(running_crc, byte_q);
    end
    if (cmd.emit_start) begin
      emit_idx  <= '0;
      frame_crc <= {byte_q, crc_lo};
    end else if (cmd.emit_step) begin
      emit_idx <= next_idx;
    end
  end

  // payload store
  assign next_idx = emit_idx + 6'd1;
  assign rd_en    = cmd.emit_start || (cmd.emit_step && !sts.emit_last);
  assign rd_addr  = cmd.emit_start ? '0 : next_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.pay_write) begin
      mem[fill_count[AW-1:0]] <= byte_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  assign last_idx = (hdr_len == 7'd0) ? 7'd0 : hdr_len - 7'd1;

  always_comb begin
    sts.sync1_hit = byte_q == sync_first;
    sts.sync2_hit = byte_q == sync_second;
    sts.gap_over  = gap_over;
    sts.len_over  = byte_q > MaxLen;
    sts.byte_zero = byte_q == 8'h00;
    sts.fill_done = (fill_count + 7'd1) >= hdr_len;
    sts.crc_ok    = {byte_q, crc_lo} == running_crc;
    sts.out_free  = !out_valid || res.ready;
    sts.emit_last = {1'b0, emit_idx} == last_idx;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_single || cmd.emit_step) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_single) begin
      out_status <= cmd.single_status;
      out_dst    <= '0;
      out_src    <= '0;
      out_type   <= '0;
      out_seq    <= '0;
      out_len    <= '0;
      out_pos    <= '0;
      out_data   <= '0;
      out_crc    <= '0;
      out_last   <= 1'b1;
    end else if (cmd.emit_step) begin
      out_status <= ST_DATA;
      out_dst    <= hdr_dst;
      out_src    <= hdr_src;
      out_type   <= hdr_type;
      out_seq    <= hdr_seq;
      out_len    <= hdr_len;
      out_pos    <= emit_idx;
      out_data   <= (hdr_len == 7'd0) ? 8'h00 : mem_q;
      out_crc    <= frame_crc;
      out_last   <= sts.emit_last;
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_status;
  assign res.dst_addr    = out_dst;
  assign res.src_addr    = out_src;
  assign res.frame_type  = out_type;
  assign res.seq_num     = out_seq;
  assign res.payload_len = out_len;
  assign res.byte_pos    = out_pos;
  assign res.data_byte   = out_data;
  assign res.frame_crc   = out_crc;
  assign res.last        = out_last;

endmodule

`default_nettype wire

[rtl/core/fpp_ctrl.sv]
// controller: frame parse phase and word sequencing
`default_nettype none

module fpp_ctrl import fpp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire fpp_sts_t sts,
  output fpp_cmd_t      cmd
);

  localparam logic [1:0] SQ_IDLE = 2'd0;
  localparam logic [1:0] SQ_PROC = 2'd1;
  localparam logic [1:0] SQ_EMIT = 2'd2;

  localparam logic [3:0] PH_SYNC1   = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_DST     = 4'd2;
  localparam logic [3:0] PH_SRC     = 4'd3;
  localparam logic [3:0] PH_TYPE    = 4'd4;
  localparam logic [3:0] PH_SEQ     = 4'd5;
  localparam logic [3:0] PH_LEN     = 4'd6;
  localparam logic [3:0] PH_PAYLOAD = 4'd7;
  localparam logic [3:0] PH_CRCLO   = 4'd8;
  localparam logic [3:0] PH_CRCHI   = 4'd9;

  logic [1:0] seq;
  logic [1:0] seq_next;
  logic [3:0] phase;
  logic [3:0] phase_next;
  logic [3:0] eff_phase;

  assign in_ready  = seq == SQ_IDLE;
  // gap timeout restarts the hunt before the word is handled
  assign eff_phase = (phase != PH_SYNC1 && sts.gap_over) ? PH_SYNC1 : phase;

  always_comb begin
    cmd           = '0;
    cmd.take      = in_valid && in_ready;
    seq_next      = seq;
    phase_next    = phase;
    unique case (seq)
      SQ_IDLE: begin
        if (in_valid) seq_next = SQ_PROC;
      end
      SQ_PROC: begin
        if (sts.out_free) begin
          seq_next          = SQ_IDLE;
          cmd.out_single    = 1'b1;
          cmd.single_status = ST_NONE;
          unique case (eff_phase)
            PH_SYNC1: begin
              phase_next = sts.sync1_hit ? PH_SYNC2 : PH_SYNC1;
            end
            PH_SYNC2: begin
              priority if (sts.sync2_hit) begin
                phase_next   = PH_DST;
                cmd.crc_init = 1'b1;
              end else if (!sts.sync1_hit) begin
                phase_next = PH_SYNC1;
              end else begin
                phase_next = PH_SYNC2;
              end
            end
            PH_DST: begin
              cmd.load_dst = 1'b1;
              cmd.crc_add  = 1'b1;
              phase_next   = PH_SRC;
            end
            PH_SRC: begin
              cmd.load_src = 1'b1;
              cmd.crc_add  = 1'b1;
              phase_next   = PH_TYPE;
            end
            PH_TYPE: begin
              cmd.load_type = 1'b1;
              cmd.crc_add   = 1'b1;
              phase_next    = PH_SEQ;
            end
            PH_SEQ: begin
              cmd.load_seq = 1'b1;
              cmd.crc_add  = 1'b1;
              phase_next   = PH_LEN;
            end
            PH_LEN: begin
              if (sts.len_over) begin
                cmd.single_status = ST_ERROR;
                phase_next        = PH_SYNC1;
              end else begin
                cmd.load_len = 1'b1;
                cmd.crc_add  = 1'b1;
                phase_next   = sts.byte_zero ? PH_CRCLO : PH_PAYLOAD;
              end
            end
            PH_PAYLOAD: begin
              cmd.pay_write = 1'b1;
              cmd.crc_add   = 1'b1;
              phase_next    = sts.fill_done ? PH_CRCLO : PH_PAYLOAD;
            end
            PH_CRCLO: begin
              cmd.load_crclo = 1'b1;
              phase_next     = PH_CRCHI;
            end
            PH_CRCHI: begin
              phase_next = PH_SYNC1;
              if (sts.crc_ok) begin
                cmd.out_single = 1'b0;
                cmd.emit_start = 1'b1;
                seq_next       = SQ_EMIT;
              end else begin
                cmd.single_status = ST_ERROR;
              end
            end
            default: begin
              phase_next = PH_SYNC1;
            end
          endcase
        end
      end
      SQ_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_step = 1'b1;
          if (sts.emit_last) seq_next = SQ_IDLE;
        end
      end
      default: begin
        seq_next = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq   <= SQ_IDLE;
      phase <= PH_SYNC1;
    end else begin
      seq   <= seq_next;
      phase <= phase_next;
    end
  end

  a_take_to_proc: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (seq == SQ_PROC))
    else $error("accepted word not processed next cycle");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.out_single && cmd.emit_step))
    else $error("result register written twice in one cycle");

  a_emit_idle_phase: assert property (@(posedge clk) disable iff (rst)
    (seq == SQ_EMIT) |-> (phase == PH_SYNC1))
    else $error("frame emission while parse is in progress");

  a_emit_after_start: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_start |=> (seq == SQ_EMIT))
    else $error("emission start not followed by emission");

endmodule

`default_nettype wire

[rtl/core/framed_packet_parser_crc16_top.sv]
// top level of the sync-framed packet parser with crc-16 check
// each accepted word is captured, then handled in the proc state, which loads
//   the result register; a good frame's payload results come from the payload
//   memory through its single read port and are loaded in the emit state
// no new word is accepted until the last is handled; a good frame's final word
//   yields one result per payload byte (one for an empty frame), issued in turn
// reset: synchronous, restores config defaults and the hunt for the first sync
`default_nettype none

module framed_packet_parser_crc16_top import fpp_pkg::*; #(
  parameter int MAX_PAYLOAD = MaxPayloadDef
) (
  input wire logic  clk,
  input wire logic  rst,
  fpp_in_if.sink    rx,
  fpp_out_if.source res,
  fpp_cfg_if.sink   cfg
);

  fpp_cmd_t cmd;
  fpp_sts_t sts;
  logic     in_ready;

  assign rx.ready = in_ready;

  fpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fpp_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (rx.rx_byte),
    .time_ms (rx.time_ms),
    .cmd     (cmd),
    .sts     (sts),
    .cfg     (cfg),
    .res     (res)
  );

endmodule

`default_nettype wire
